// File: hdl/csvs_pkg.sv
`default_nettype none
package csvs_pkg;

    // request kinds
    localparam logic [1:0] FUNC_VICTIM = 2'd0;
    localparam logic [1:0] FUNC_PIN    = 2'd1;
    localparam logic [1:0] FUNC_UNPIN  = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_BUFFERS_IN_USE = 1'b0;
    localparam logic REG_MAX_USAGE      = 1'b1;

    localparam logic [6:0] BUFFERS_RESET   = 7'd64;
    localparam logic [2:0] MAX_USAGE_RESET = 3'd5;

    // field widths
    localparam int PIN_W   = 8;
    localparam int USE_W   = 3;
    localparam int ENTRY_W = PIN_W + USE_W;
    localparam int POS_W   = 7;   // hand and pool size, pool is at most 127
    localparam int STEP_W  = 8;   // up to two passes of 127
    localparam int BIT_W   = 3;

    localparam logic [PIN_W-1:0] PIN_MAX  = 8'd255;
    localparam logic [BIT_W-1:0] LAST_BIT = 3'(POS_W - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD,
        S_EVAL,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// File: hdl/csvs_ram.sv
`default_nettype none
module csvs_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 64
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire  [$clog2(DEPTH)-1:0] waddr,
    input  wire  [WIDTH-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/clock_sweep_victim_select_unit.sv
`default_nettype none
// Clock-sweep victim selection with per-buffer pin and usage counts.
// Input channel (in_valid/in_ready) carries one request word: func selects
// victim search, pin or unpin, buffer_index names the buffer for pin/unpin.
// Output channel (out_valid/out_ready) returns exactly one word per request:
// found, victim_index, from_free_list (all zero for pin, unpin, unknown func).
// Pin and usage counts live in one synchronous RAM, read then written back.
// Steps to out_valid, with the output register free:
//   pin / unpin                : read, modify-write, hand over
//   never-used buffer, bad func: handed over directly
//   sweep                      : up to 2n buffers visited, n the clamped
//                                pool size; the hand is first reduced modulo n,
//                                one hand bit a cycle, and each visit is a RAM
//                                read, then a usage write-back if unpinned and not chosen.
// One request is in flight at a time; in_ready rises again once the word
// has gone to the output register, so a new request can be taken while the
// last word still waits there. A stalled receiver holds the finished word
// in a staging register and blocks further requests.
// After rst_n the RAM is cleared, one entry a cycle, all NUM_BUFFERS entries,
// with in_ready low. Configuration writes are taken at any time but must
// only be made while the block is idle.
module clock_sweep_victim_select_unit #(
    parameter int NUM_BUFFERS = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    // request channel
    input  wire         in_valid,
    output logic        in_ready,
    input  wire  [1:0]  func,
    input  wire  [5:0]  buffer_index,
    // result channel
    output logic        out_valid,
    input  wire         out_ready,
    output logic        found,
    output logic [5:0]  victim_index,
    output logic        from_free_list,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import csvs_pkg::*;

    localparam int AW = $clog2(NUM_BUFFERS);
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_BUFFERS - 1);
    localparam logic [POS_W-1:0] POOL_CAP =
        POS_W'((NUM_BUFFERS > 127) ? 127 : NUM_BUFFERS);

    // configuration
    logic [6:0] buffers_in_use_reg;
    logic [2:0] max_usage_reg;
    logic       cfg_we;

    // control and datapath registers
    state_t state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [POS_W-1:0]  pos_reg, pos_next;      // sweep position or pin target
    logic [POS_W-1:0]  hand_reg, hand_next;    // clock hand
    logic [6:0]        next_fresh_reg, next_fresh_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [POS_W-1:0]  rem_reg, rem_next;      // hand modulo n, partial remainder
    logic [POS_W-1:0]  div_reg, div_next;      // hand bits still to shift in
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [AW-1:0]     clr_reg, clr_next;

    // staged result and output register
    logic       res_found_reg, res_found_next;
    logic [5:0] res_victim_reg, res_victim_next;
    logic       res_fresh_reg, res_fresh_next;
    logic       out_valid_reg, out_valid_next;
    logic       found_reg, found_next;
    logic [5:0] victim_reg, victim_next;
    logic       fresh_reg, fresh_next;

    // RAM
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // helpers
    logic [POS_W-1:0]  pool_n;
    logic [31:0]       pos_ext;
    logic [AW-1:0]     pos_addr;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  pos_wrap;
    logic [STEP_W-1:0] step_inc;
    logic [STEP_W-1:0] step_limit;
    logic [POS_W:0]    trial;
    logic [POS_W-1:0]  rem_new;
    logic [PIN_W-1:0]  rd_pin;
    logic [USE_W-1:0]  rd_use;
    logic              hit;
    logic              idx_ok;
    logic              fresh_avail;
    logic              out_free;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffers_in_use_reg <= BUFFERS_RESET;
            max_usage_reg      <= MAX_USAGE_RESET;
        end
        else if (cfg_we)
        begin
            case (paddr[2])
                REG_BUFFERS_IN_USE: buffers_in_use_reg <= pwdata[6:0];
                REG_MAX_USAGE:      max_usage_reg      <= pwdata[2:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BUFFERS_IN_USE: prdata = {25'd0, buffers_in_use_reg};
            REG_MAX_USAGE:      prdata = {29'd0, max_usage_reg};
            default:            prdata = 32'd0;
        endcase
    end

    // ---------------- shared helpers ----------------
    // pool size clamped to 1..NUM_BUFFERS
    always_comb
    begin
        if (buffers_in_use_reg == 7'd0)
        begin
            pool_n = POS_W'(1);
        end
        else if (32'(buffers_in_use_reg) > NUM_BUFFERS)
        begin
            pool_n = POOL_CAP;
        end
        else
        begin
            pool_n = buffers_in_use_reg;
        end
    end

    assign pos_ext     = 32'(pos_reg);
    assign pos_addr    = pos_ext[AW-1:0];
    assign pos_inc     = pos_reg + POS_W'(1);
    assign pos_wrap    = (pos_inc == pool_n) ? '0 : pos_inc;
    assign step_inc    = step_reg + STEP_W'(1);
    assign step_limit  = {pool_n, 1'b0};
    assign rd_pin      = ram_rdata[ENTRY_W-1:USE_W];
    assign rd_use      = ram_rdata[USE_W-1:0];
    assign hit         = (rd_pin == '0) && (rd_use == '0);
    assign idx_ok      = 32'(buffer_index) < NUM_BUFFERS;
    assign fresh_avail = next_fresh_reg < pool_n;
    assign out_free    = !out_valid_reg || out_ready;

    // restoring remainder step: one hand bit a cycle
    assign trial   = {rem_reg, div_reg[POS_W-1]};
    assign rem_new = (trial >= {1'b0, pool_n}) ? POS_W'(trial - {1'b0, pool_n})
                                               : trial[POS_W-1:0];

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CLR_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (func == FUNC_VICTIM)
                    begin
                        state_next = fresh_avail ? S_DONE : S_MOD;
                    end
                    else if ((func == FUNC_PIN || func == FUNC_UNPIN) && idx_ok)
                    begin
                        state_next = S_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_MOD:
            begin
                if (bit_reg == LAST_BIT)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (op_reg != FUNC_VICTIM || hit || step_inc == step_limit)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        op_next         = op_reg;
        pos_next        = pos_reg;
        hand_next       = hand_reg;
        next_fresh_next = next_fresh_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        bit_next        = bit_reg;
        clr_next        = clr_reg;
        res_found_next  = res_found_reg;
        res_victim_next = res_victim_reg;
        res_fresh_next  = res_fresh_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        victim_next     = victim_reg;
        fresh_next      = fresh_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_addr;
        ram_wdata       = '0;
        ram_raddr       = pos_addr;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = func;
                    pos_next        = {1'b0, buffer_index};
                    res_found_next  = 1'b0;
                    res_victim_next = '0;
                    res_fresh_next  = 1'b0;
                    rem_next        = '0;
                    div_next        = hand_reg;
                    bit_next        = '0;
                    if (func == FUNC_VICTIM && fresh_avail)
                    begin
                        res_found_next  = 1'b1;
                        res_victim_next = next_fresh_reg[5:0];
                        res_fresh_next  = 1'b1;
                        next_fresh_next = next_fresh_reg + 7'd1;
                    end
                end
            end
            S_MOD:
            begin
                rem_next = rem_new;
                div_next = {div_reg[POS_W-2:0], 1'b0};
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == LAST_BIT)
                begin
                    pos_next  = rem_new;
                    step_next = '0;
                end
            end
            S_RD:
            begin
                // read issued at pos_addr, data valid in S_EVAL
            end
            S_EVAL:
            begin
                case (op_reg)
                    FUNC_PIN:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {(rd_pin != PIN_MAX) ? rd_pin + PIN_W'(1) : rd_pin,
                                     (rd_use < max_usage_reg) ? rd_use + USE_W'(1) : rd_use};
                    end
                    FUNC_UNPIN:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {(rd_pin != '0) ? rd_pin - PIN_W'(1) : rd_pin, rd_use};
                    end
                    FUNC_VICTIM:
                    begin
                        if (hit)
                        begin
                            res_found_next  = 1'b1;
                            res_victim_next = pos_reg[5:0];
                            hand_next       = pos_wrap;
                        end
                        else
                        begin
                            if (rd_pin == '0)
                            begin
                                ram_we    = 1'b1;
                                ram_wdata = {rd_pin, rd_use - USE_W'(1)};
                            end
                            step_next = step_inc;
                            pos_next  = pos_wrap;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    found_next     = res_found_reg;
                    victim_next    = res_victim_reg;
                    fresh_next     = res_fresh_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            hand_reg       <= '0;
            next_fresh_reg <= '0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hand_reg       <= hand_next;
            next_fresh_reg <= next_fresh_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        div_reg        <= div_next;
        bit_reg        <= bit_next;
        res_found_reg  <= res_found_next;
        res_victim_reg <= res_victim_next;
        res_fresh_reg  <= res_fresh_next;
        found_reg      <= found_next;
        victim_reg     <= victim_next;
        fresh_reg      <= fresh_next;
    end

    csvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BUFFERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign found          = found_reg;
    assign victim_index   = victim_reg;
    assign from_free_list = fresh_reg;

    // ---------------- assertions ----------------
    // sweep position lies inside the pool at each sweep read
    a_pos_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD && op_reg == FUNC_VICTIM) |-> (pos_reg < pool_n))
        else $error("sweep position outside pool");

    // the never-used pointer only moves forward
    a_fresh_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR) |=> (next_fresh_reg >= $past(next_fresh_reg)))
        else $error("next_fresh went backwards");

    // RAM writes come only from the clearing pass or a write-back
    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_EVAL))
        else $error("unexpected RAM write");

    // a finished word waits while the output register is still full
    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result staged over an untaken word");

endmodule
`default_nettype wire

// File: bench/clock_sweep_victim_select_unit_tb.sv
`default_nettype none
module clock_sweep_victim_select_unit_tb;

    import csvs_pkg::*;

    // ------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------
    localparam int NUM_BUFS = 64;

    // func value the block has no use for; must leave all state alone
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // byte addresses of the two registers (register index in paddr[2])
    localparam logic [2:0] ADDR_POOL      = {REG_BUFFERS_IN_USE, 2'b00};
    localparam logic [2:0] ADDR_MAX_USAGE = {REG_MAX_USAGE, 2'b00};

    // quiet cycles before a register write once the last word is back
    localparam int SETTLE_CYCLES = 8;
    // the tail covers the longest search, with n = 64
    localparam int TAIL_CYCLES   = 300;
    // receiver hold-off long enough to fill the output and staging registers
    localparam int LONG_HOLD     = 200;
    localparam int MAX_REPORTS   = 10;

    // one result word, plus the request kind it answers (not compared)
    typedef struct packed {
        logic [1:0] kind;
        logic       found;
        logic [5:0] victim;
        logic       fresh;
    } victim_word_t;

    // ------------------------------------------------------------------
    // Block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = FUNC_VICTIM;
    logic [5:0]  buffer_index = 6'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        found;
    logic [5:0]  victim_index;
    logic        from_free_list;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    clock_sweep_victim_select_unit #(
        .NUM_BUFFERS (NUM_BUFS)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .buffer_index   (buffer_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .found          (found),
        .victim_index   (victim_index),
        .from_free_list (from_free_list),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the pool, updated as each request word is accepted
    // ------------------------------------------------------------------
    logic [7:0] shadow_pins  [NUM_BUFS] = '{default: 8'd0};
    logic [2:0] shadow_usage [NUM_BUFS] = '{default: 3'd0};
    logic [5:0] shadow_hand = 6'd0;
    logic [6:0] shadow_fresh = 7'd0;
    logic [6:0] shadow_pool = BUFFERS_RESET;
    logic [2:0] shadow_max_usage = MAX_USAGE_RESET;

    // result words still owed by the block, oldest first
    victim_word_t expected_words [$];

    // idling knobs, in percent
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // long hold-off requests: main flow raises asked, receiver raises served
    int long_holds_asked  = 0;
    int long_holds_served = 0;
    int hold_left         = 0;

    // bookkeeping
    int mismatch_count  = 0;
    int words_sent      = 0;
    int words_checked   = 0;
    int fresh_victims   = 0;
    int swept_victims   = 0;
    int failed_searches = 0;
    int config_writes   = 0;

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // timeout, far beyond the slowest legal run
    initial
    begin
        #6000000;
        $display("Regression FAIL");
        $display("timeout: %0d words sent, %0d still owed", words_sent,
                 expected_words.size());
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // pool size as the sweep sees it: register clamped to 1..NUM_BUFS
    function automatic int pool_clamped();
        int n;
        n = shadow_pool;
        if (n < 1)
            n = 1;
        if (n > NUM_BUFS)
            n = NUM_BUFS;
        return n;
    endfunction

    // Applies one request to the shadow pool and returns the word it causes.
    function automatic victim_word_t predict_victim_word(input logic [1:0] f,
                                                         input logic [5:0] idx);
        victim_word_t w;
        int n;
        int pos;
        w = '0;
        w.kind = f;
        case (f)
            FUNC_PIN:
            begin
                if (shadow_pins[idx] != PIN_MAX)
                    shadow_pins[idx] = shadow_pins[idx] + 8'd1;
                // a count above a lowered limit stays where it is
                if (shadow_usage[idx] < shadow_max_usage)
                    shadow_usage[idx] = shadow_usage[idx] + 3'd1;
            end
            FUNC_UNPIN:
            begin
                if (shadow_pins[idx] != 8'd0)
                    shadow_pins[idx] = shadow_pins[idx] - 8'd1;
            end
            FUNC_VICTIM:
            begin
                n = pool_clamped();
                if (shadow_fresh < n)
                begin
                    // never-used buffers go first, pinned or not
                    w.found  = 1'b1;
                    w.fresh  = 1'b1;
                    w.victim = shadow_fresh[5:0];
                    shadow_fresh = shadow_fresh + 7'd1;
                end
                else
                begin
                    // hand may sit beyond a shrunk pool
                    pos = shadow_hand % n;
                    for (int i = 0; i < 2 * n; i++)
                    begin
                        if (shadow_pins[6'(pos)] == 8'd0)
                        begin
                            if (shadow_usage[6'(pos)] != 3'd0)
                                shadow_usage[6'(pos)] = shadow_usage[6'(pos)] - 3'd1;
                            else
                            begin
                                w.found = 1'b1;
                                w.victim = 6'(pos);
                                shadow_hand = 6'((pos + 1) % n);
                                break;
                            end
                        end
                        pos = (pos + 1) % n;
                    end
                    // a failed sweep keeps its decrements, hand unmoved
                end
            end
            default: ;
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what,
                     want, got);
    endfunction

    // Receiver: random stalls, or a long hold-off counted here on request.
    always @(posedge clk)
    begin
        if (long_holds_served != long_holds_asked)
        begin
            long_holds_served <= long_holds_served + 1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Checker: each word taken is matched against the oldest one owed.
    always @(posedge clk)
    begin : result_checker
        victim_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                note_mismatch("word with nothing owed, victim_index", 32'd0,
                              32'(victim_index));
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (found !== want.found)
                    note_mismatch("found", 32'(want.found), 32'(found));
                if (victim_index !== want.victim)
                    note_mismatch("victim_index", 32'(want.victim), 32'(victim_index));
                if (from_free_list !== want.fresh)
                    note_mismatch("from_free_list", 32'(want.fresh),
                                  32'(from_free_list));
                if (want.kind == FUNC_VICTIM)
                begin
                    if (!want.found)
                        failed_searches++;
                    else if (want.fresh)
                        fresh_victims++;
                    else
                        swept_victims++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one request word and returns at the edge where it is taken.
    task automatic send_word(input logic [1:0] f, input logic [5:0] idx);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        buffer_index <= idx;
        do
            @(posedge clk);
        while (!in_ready);
        expected_words.push_back(predict_victim_word(f, idx));
        words_sent++;
    endtask

    task automatic send_repeated(input logic [1:0] f, input logic [5:0] idx,
                                 input int count);
        repeat (count) send_word(f, idx);
    endtask

    // Lets every owed word come back, then a few quiet cycles.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write over the config port, then a read-back of the field.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] readback;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_POOL)
            shadow_pool = value[6:0];
        else
            shadow_max_usage = value[2:0];
        config_writes++;
        // straight into the setup phase of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_POOL)
        begin
            if (readback[6:0] !== value[6:0])
                note_mismatch("buffers_in_use read-back", 32'(value[6:0]),
                              32'(readback[6:0]));
        end
        else if (readback[2:0] !== value[2:0])
            note_mismatch("max_usage read-back", 32'(value[2:0]), 32'(readback[2:0]));
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= stall_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fresh buffers handed out in order, a pinned one included, then the
    // first sweeps over a tiny pool; unknown func and unpin at zero on the way.
    task automatic test_fresh_handout();
        send_word(FUNC_PIN, 6'd0);
        send_word(FUNC_UNPIN, 6'd1);
        send_word(FUNC_UNUSED, 6'd63);
        send_word(FUNC_PIN, 6'd63);
        send_word(FUNC_UNPIN, 6'd63);
        send_word(FUNC_VICTIM, 6'd0);
        write_register(ADDR_POOL, 32'd3);
        send_repeated(FUNC_VICTIM, 6'd0, 4);
        send_word(FUNC_PIN, 6'd1);
        send_word(FUNC_PIN, 6'd2);
        send_repeated(FUNC_VICTIM, 6'd0, 3);
        send_word(FUNC_UNPIN, 6'd0);
        send_repeated(FUNC_VICTIM, 6'd0, 2);
    endtask

    // All pinned, and usage too high to drain within two passes.
    task automatic test_no_victim();
        write_register(ADDR_POOL, 32'd1);
        send_word(FUNC_PIN, 6'd0);
        send_word(FUNC_VICTIM, 6'd0);
        send_word(FUNC_UNPIN, 6'd0);
        write_register(ADDR_MAX_USAGE, 32'd7);
        send_repeated(FUNC_PIN, 6'd0, 4);
        send_repeated(FUNC_UNPIN, 6'd0, 4);
        send_repeated(FUNC_VICTIM, 6'd0, 3);
        // pool register zero behaves as a pool of one
        write_register(ADDR_POOL, 32'd0);
        send_word(FUNC_VICTIM, 6'd0);
        // usage limit zero: pins no longer raise usage
        write_register(ADDR_MAX_USAGE, 32'd0);
        send_word(FUNC_PIN, 6'd0);
        send_word(FUNC_UNPIN, 6'd0);
        send_repeated(FUNC_VICTIM, 6'd0, 2);
    endtask

    // Pin count held at 255, usage held at the limit and above a lowered one.
    task automatic test_pin_saturation();
        write_register(ADDR_POOL, 32'd8);
        write_register(ADDR_MAX_USAGE, 32'd7);
        send_repeated(FUNC_PIN, 6'd5, 260);
        send_repeated(FUNC_VICTIM, 6'd0, 4);
        write_register(ADDR_MAX_USAGE, 32'd1);
        send_word(FUNC_PIN, 6'd5);
        send_repeated(FUNC_UNPIN, 6'd5, 3);
        send_repeated(FUNC_VICTIM, 6'd0, 2);
    endtask

    // Walk the hand round a larger pool, then shrink the pool under it.
    task automatic test_hand_beyond_pool();
        write_register(ADDR_POOL, 32'd16);
        write_register(ADDR_MAX_USAGE, 32'd2);
        send_word(FUNC_PIN, 6'd3);
        send_repeated(FUNC_VICTIM, 6'd0, 24);
        write_register(ADDR_POOL, 32'd5);
        send_repeated(FUNC_VICTIM, 6'd0, 4);
    endtask

    // Receiver holds off long enough that the block stops taking requests.
    task automatic test_output_backpressure();
        write_register(ADDR_POOL, 32'd8);
        set_idling(0, 0);
        long_holds_asked <= long_holds_asked + 1;
        @(posedge clk);
        for (int i = 0; i < 12; i++)
            send_word((i % 3 == 0) ? FUNC_VICTIM : FUNC_PIN, 6'(i % 8));
        send_repeated(FUNC_UNPIN, 6'd1, 4);
    endtask

    task automatic write_random_config();
        int r;
        logic [6:0] pool;
        r = $urandom_range(99);
        if (r < 55)
            pool = 7'($urandom_range(1, 8));
        else if (r < 80)
            pool = 7'($urandom_range(9, 40));
        else
            case ($urandom_range(3))
                0: pool = 7'd0;
                1: pool = 7'd64;
                2: pool = 7'd127;
                default: pool = 7'($urandom_range(65, 126));
            endcase
        write_register(ADDR_POOL, 32'(pool));
        write_register(ADDR_MAX_USAGE, 32'($urandom_range(0, 7)));
    endtask

    // Mixed traffic, mostly aimed inside the current pool so that pins and
    // unpins shape the sweeps.
    task automatic send_random_word();
        int r;
        logic [1:0] f;
        logic [5:0] idx;
        r = $urandom_range(99);
        if (r < 35)
            f = FUNC_VICTIM;
        else if (r < 65)
            f = FUNC_PIN;
        else if (r < 97)
            f = FUNC_UNPIN;
        else
            f = FUNC_UNUSED;
        if ($urandom_range(9) < 8)
            idx = 6'($urandom_range(pool_clamped() - 1));
        else
            idx = 6'($urandom_range(63));
        send_word(f, idx);
    endtask

    // Random traffic in chunks, a fresh configuration before each chunk.
    task automatic test_random_traffic(input int send_pct, input int stall_pct);
        set_idling(send_pct, stall_pct);
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            write_random_config();
            repeat (120) send_random_word();
        end
    endtask

    // ------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fresh_handout();
        test_no_victim();
        test_pin_saturation();
        test_hand_beyond_pool();
        test_output_backpressure();

        // full pool and top usage limit once for certain
        write_register(ADDR_POOL, 32'd64);
        write_register(ADDR_MAX_USAGE, 32'd7);
        test_random_traffic(0, 0);
        test_random_traffic(61, 0);
        test_random_traffic(0, 61);
        test_random_traffic(15, 15);
        set_idling(0, 0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d words checked, %0d register writes",
                 words_sent, words_checked, config_writes);
        $display("searches: %0d fresh, %0d swept, %0d with no victim; %0d mismatches",
                 fresh_victims, swept_victims, failed_searches, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// File: clock_sweep_victim_select_unit.f
hdl/csvs_pkg.sv
hdl/csvs_ram.sv
hdl/clock_sweep_victim_select_unit.sv
bench/clock_sweep_victim_select_unit_tb.sv
